/* hw/rtl/cpp_pkg.sv */
`timescale 1ns / 1ps
package cpp_pkg;

  localparam int NUM_COEF        = 22;
  localparam int COORD_WIDTH_DEF = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PROJ = 1'b1;

  localparam logic [4:0] CI_T0   = 5'd9;
  localparam logic [4:0] CI_FX   = 5'd12;
  localparam logic [4:0] CI_SKEW = 5'd13;
  localparam logic [4:0] CI_CX   = 5'd14;
  localparam logic [4:0] CI_FY   = 5'd15;
  localparam logic [4:0] CI_CY   = 5'd16;
  localparam logic [4:0] CI_K1   = 5'd17;
  localparam logic [4:0] CI_K2   = 5'd18;
  localparam logic [4:0] CI_P1   = 5'd19;
  localparam logic [4:0] CI_P2   = 5'd20;
  localparam logic [4:0] CI_K3   = 5'd21;

  localparam logic signed [31:0] Q28_ONE = 32'sh1000_0000;

  typedef struct packed {
    logic               cmd;
    logic [4:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
  } item_t;

  // {clamped, value}
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  function automatic logic [32:0] mulq28(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 28;
    return sat32(s);
  endfunction

endpackage

/* hw/rtl/camera_point_projection.sv */
// camera_point_projection: pinhole projection with radial and tangential lens distortion
// the path from the accepting edge to out_valid is set mostly by the 31-stage divider
// throughput: one projection item per cycle; a coefficient load waits until the datapath drains
// busy rises only when the two-entry item queue is full; results cannot be held off
// reset: synchronous on rst_n low, clears the queue, all stage valids and the coefficient store
`timescale 1ns / 1ps
module camera_point_projection #(
  parameter int COORD_WIDTH = cpp_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic [4:0]         in_coef_index,
  input  logic signed [31:0] in_coef_value,
  input  logic signed [31:0] in_world_x,
  input  logic signed [31:0] in_world_y,
  input  logic signed [31:0] in_world_z,
  output logic               out_valid,
  output logic signed [31:0] out_pixel_x,
  output logic signed [31:0] out_pixel_y,
  output logic               out_in_front,
  output logic               out_saturated
);
  import cpp_pkg::*;

  item_t push_item;
  item_t head;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_not_empty;

  cpp_front u_front (
    .start         (start),
    .in_cmd        (in_cmd),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_world_x    (in_world_x),
    .in_world_y    (in_world_y),
    .in_world_z    (in_world_z),
    .q_full        (q_full),
    .busy          (busy),
    .push          (push),
    .push_item     (push_item)
  );

  cpp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  cpp_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .head_vld      (q_not_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_in_front  (out_in_front),
    .out_saturated (out_saturated)
  );

endmodule

/* hw/rtl/cpp_queue.sv */
`timescale 1ns / 1ps
module cpp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cpp_pkg::item_t push_item,
  input  logic           pop,
  output cpp_pkg::item_t head,
  output logic           not_empty,
  output logic           full
);
  import cpp_pkg::*;

  item_t      slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign head      = slot_r[rp_r];
  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hw/rtl/cpp_front.sv */
`timescale 1ns / 1ps
module cpp_front (
  input  logic               start,
  input  logic               in_cmd,
  input  logic [4:0]         in_coef_index,
  input  logic signed [31:0] in_coef_value,
  input  logic signed [31:0] in_world_x,
  input  logic signed [31:0] in_world_y,
  input  logic signed [31:0] in_world_z,
  input  logic               q_full,
  output logic               busy,
  output logic               push,
  output cpp_pkg::item_t     push_item
);
  import cpp_pkg::*;

  logic accept;
  logic keep;

  assign busy   = q_full;
  assign accept = start && !q_full;
  // loads beyond the store are dropped here
  assign keep   = (in_cmd == CMD_PROJ) || (in_coef_index < 5'(NUM_COEF));
  assign push   = accept && keep;

  always_comb begin
    push_item.cmd = in_cmd;
    push_item.idx = in_coef_index;
    push_item.val = in_coef_value;
    push_item.wx  = in_world_x;
    push_item.wy  = in_world_y;
    push_item.wz  = in_world_z;
  end

endmodule

/* hw/rtl/cpp_back.sv */
`timescale 1ns / 1ps
module cpp_back #(
  parameter int COORD_WIDTH = cpp_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cpp_pkg::item_t     head,
  input  logic               head_vld,
  output logic               pop,
  output logic               out_valid,
  output logic signed [31:0] out_pixel_x,
  output logic signed [31:0] out_pixel_y,
  output logic               out_in_front,
  output logic               out_saturated
);
  import cpp_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int AW    = (CW > 36) ? CW : 36;
  localparam int NDIV  = 31;
  localparam int NPOST = 15;
  localparam logic signed [AW-1:0] CHI = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [AW-1:0] CLO = ~CHI;

  typedef struct packed {
    logic          vld;
    logic          inf;
    logic          sat;
    logic          sx;
    logic          sy;
    logic          ovx;
    logic          ovy;
    logic [CW-1:0] den;
    logic [CW-1:0] rx;
    logic [CW-1:0] ry;
    logic [NDIV-1:0] qx;
    logic [NDIV-1:0] qy;
  } dv_t;

  typedef struct packed {
    logic vld;
    logic inf;
    logic sat;
  } ctl_t;

  // coefficient store
  logic signed [31:0] coef_r [NUM_COEF];
  logic               pipe_busy;
  logic               ld_go;

  assign ld_go = head_vld && (head.cmd == CMD_LOAD) && !pipe_busy;
  assign pop   = head_vld && ((head.cmd == CMD_PROJ) || !pipe_busy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (ld_go) begin
      coef_r[head.idx] <= head.val;
    end
  end

  // rotation products
  logic signed [31:0] wv [3];
  logic               a_vld_r;
  logic signed [63:0] a_p_r [9];

  assign wv[0] = head.wx;
  assign wv[1] = head.wy;
  assign wv[2] = head.wz;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      a_p_r[i] <= coef_r[i] * wv[i % 3];
    end
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= head_vld && (head.cmd == CMD_PROJ);
    end
  end

  // translation sum
  logic               b_vld_r;
  logic signed [AW-1:0] b_acc_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      b_acc_r[k] <= AW'(coef_r[CI_T0 + 5'(k)]) + AW'(a_p_r[3*k] >>> 30)
                  + AW'(a_p_r[3*k+1] >>> 30) + AW'(a_p_r[3*k+2] >>> 30);
    end
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  // camera-space clamp
  logic               c_vld_r;
  logic               c_sat_r;
  logic signed [CW-1:0] c_c_r [3];
  logic signed [CW-1:0] c_c_nxt [3];
  logic                 c_sat_nxt;

  always_comb begin
    c_sat_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (b_acc_r[k] > CHI) begin
        c_c_nxt[k] = CHI[CW-1:0];
        c_sat_nxt  = 1'b1;
      end else if (b_acc_r[k] < CLO) begin
        c_c_nxt[k] = CLO[CW-1:0];
        c_sat_nxt  = 1'b1;
      end else begin
        c_c_nxt[k] = b_acc_r[k][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    c_c_r   <= c_c_nxt;
    c_sat_r <= c_sat_nxt;
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
  end

  // divider setup
  dv_t           dv [NDIV+1];
  dv_t           d_r;
  dv_t           d_nxt;
  logic [CW-1:0] ax;
  logic [CW-1:0] ay;

  always_comb begin
    ax = c_c_r[0][CW-1] ? CW'(-c_c_r[0]) : c_c_r[0];
    ay = c_c_r[1][CW-1] ? CW'(-c_c_r[1]) : c_c_r[1];
    d_nxt.vld = c_vld_r;
    d_nxt.inf = (c_c_r[2] > 0);
    d_nxt.sat = c_sat_r;
    d_nxt.sx  = c_c_r[0][CW-1];
    d_nxt.sy  = c_c_r[1][CW-1];
    d_nxt.den = c_c_r[2];
    d_nxt.ovx = ({3'b000, ax} >= {c_c_r[2], 3'b000});
    d_nxt.ovy = ({3'b000, ay} >= {c_c_r[2], 3'b000});
    d_nxt.rx  = ax;
    d_nxt.ry  = ay;
    d_nxt.qx  = '0;
    d_nxt.qy  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else begin
      d_r <= d_nxt;
    end
  end

  assign dv[0] = d_r;

  // restoring divider, one quotient bit per stage
  for (genvar s = 0; s < NDIV; s++) begin : g_div
    localparam int SH = (s < 3) ? (2 - s) : 0;
    dv_t           st_r;
    dv_t           st_nxt;
    logic [CW+2:0] tx;
    logic [CW+2:0] ty;
    logic [CW+2:0] dd;
    logic          bx;
    logic          by;

    always_comb begin
      dd = {3'b000, dv[s].den} << SH;
      if (s < 3) begin
        tx = {3'b000, dv[s].rx};
        ty = {3'b000, dv[s].ry};
      end else begin
        tx = {2'b00, dv[s].rx, 1'b0};
        ty = {2'b00, dv[s].ry, 1'b0};
      end
      bx = (tx >= dd);
      by = (ty >= dd);
      st_nxt    = dv[s];
      st_nxt.rx = bx ? CW'(tx - dd) : CW'(tx);
      st_nxt.ry = by ? CW'(ty - dd) : CW'(ty);
      st_nxt.qx = {dv[s].qx[NDIV-2:0], bx};
      st_nxt.qy = {dv[s].qy[NDIV-2:0], by};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r.vld <= 1'b0;
      end else begin
        st_r <= st_nxt;
      end
    end

    assign dv[s+1] = st_r;
  end

  // distortion and intrinsics
  ctl_t               ctl_r   [NPOST];
  ctl_t               ctl_nxt [NPOST];
  logic [NPOST-1:0]   sf;
  logic signed [31:0] lx_r [11];
  logic signed [31:0] ly_r [11];
  logic [NDIV-1:0]    xm;
  logic [NDIV-1:0]    ym;
  logic signed [31:0] x_e;
  logic signed [31:0] y_e;

  logic signed [63:0] f_xx_r, f_yy_r, f_xy_r;
  logic signed [31:0] g_xx_r, g_yy_r, g_xy_r;
  logic signed [31:0] h_r2_r, h_xx_r, h_yy_r, h_xy_r;
  logic signed [63:0] i_r2r2_r, i_k1r2_r;
  logic signed [31:0] i_r2_r, i_a_r, i_b_r, i_xy_r;
  logic signed [31:0] j_r4_r, j_m17_r, j_r2_r, j_a_r, j_b_r, j_xy_r;
  logic signed [63:0] k_r6p_r, k_m18p_r, k_t1p_r, k_t2p_r, k_t3p_r, k_t4p_r;
  logic signed [31:0] k_m17_r;
  logic signed [31:0] l_r6_r, l_m17_r, l_m18_r, l_t1_r, l_t2_r, l_t3_r, l_t4_r;
  logic signed [63:0] m_m21p_r;
  logic signed [31:0] m_m17_r, m_m18_r, m_t1_r, m_t2_r, m_t3_r, m_t4_r;
  logic signed [31:0] n_m21_r, n_m17_r, n_m18_r, n_t1_r, n_t2_r, n_t3_r, n_t4_r;
  logic signed [31:0] o_rad_r, o_t1_r, o_t2_r, o_t3_r, o_t4_r;
  logic signed [63:0] p_xr_r, p_yr_r;
  logic signed [31:0] p_t1_r, p_t2_r, p_t3_r, p_t4_r;
  logic signed [31:0] q_mx_r, q_my_r, q_t1_r, q_t2_r, q_t3_r, q_t4_r;
  logic signed [31:0] r_dx_r, r_dy_r;
  logic signed [63:0] s_fx_r, s_sk_r, s_fy_r;

  logic [32:0] sg_xx, sg_yy, sg_xy, sh_r2, si_a, si_b, sj_r4, sj_m17;
  logic [32:0] sl_r6, sl_m18, sl_t1, sl_t2, sl_t3, sl_t4, sn_m21, so_rad;
  logic [32:0] sq_mx, sq_my, sr_dx, sr_dy, st_u, st_v;

  always_comb begin
    xm  = dv[NDIV].ovx ? {NDIV{1'b1}} : dv[NDIV].qx;
    ym  = dv[NDIV].ovy ? {NDIV{1'b1}} : dv[NDIV].qy;
    x_e = dv[NDIV].sx ? -$signed({1'b0, xm}) : $signed({1'b0, xm});
    y_e = dv[NDIV].sy ? -$signed({1'b0, ym}) : $signed({1'b0, ym});

    sg_xx  = mulq28(f_xx_r);
    sg_yy  = mulq28(f_yy_r);
    sg_xy  = mulq28(f_xy_r);
    sh_r2  = sat32(64'(g_xx_r) + 64'(g_yy_r));
    si_a   = sat32(64'(h_r2_r) + (64'(h_xx_r) <<< 1));
    si_b   = sat32(64'(h_r2_r) + (64'(h_yy_r) <<< 1));
    sj_r4  = mulq28(i_r2r2_r);
    sj_m17 = mulq28(i_k1r2_r);
    sl_r6  = mulq28(k_r6p_r);
    sl_m18 = mulq28(k_m18p_r);
    sl_t1  = mulq28(k_t1p_r);
    sl_t2  = mulq28(k_t2p_r);
    sl_t3  = mulq28(k_t3p_r);
    sl_t4  = mulq28(k_t4p_r);
    sn_m21 = mulq28(m_m21p_r);
    so_rad = sat32(64'(Q28_ONE) + 64'(n_m17_r) + 64'(n_m18_r) + 64'(n_m21_r));
    sq_mx  = mulq28(p_xr_r);
    sq_my  = mulq28(p_yr_r);
    sr_dx  = sat32(64'(q_mx_r) + (64'(q_t1_r) <<< 1) + 64'(q_t2_r));
    sr_dy  = sat32(64'(q_my_r) + 64'(q_t3_r) + (64'(q_t4_r) <<< 1));
    st_u   = sat32((s_fx_r >>> 28) + (s_sk_r >>> 28) + 64'(coef_r[CI_CX]));
    st_v   = sat32((s_fy_r >>> 28) + 64'(coef_r[CI_CY]));

    sf     = '0;
    sf[0]  = dv[NDIV].ovx | dv[NDIV].ovy;
    sf[2]  = sg_xx[32] | sg_yy[32] | sg_xy[32];
    sf[3]  = sh_r2[32];
    sf[4]  = si_a[32] | si_b[32];
    sf[5]  = sj_r4[32] | sj_m17[32];
    sf[7]  = sl_r6[32] | sl_m18[32] | sl_t1[32] | sl_t2[32] | sl_t3[32] | sl_t4[32];
    sf[9]  = sn_m21[32];
    sf[10] = so_rad[32];
    sf[12] = sq_mx[32] | sq_my[32];
    sf[13] = sr_dx[32] | sr_dy[32];

    ctl_nxt[0].vld = dv[NDIV].vld;
    ctl_nxt[0].inf = dv[NDIV].inf;
    ctl_nxt[0].sat = dv[NDIV].sat | sf[0];
    for (int k = 1; k < NPOST; k++) begin
      ctl_nxt[k]     = ctl_r[k-1];
      ctl_nxt[k].sat = ctl_r[k-1].sat | sf[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NPOST; k++) begin
      if (!rst_n) begin
        ctl_r[k].vld <= 1'b0;
      end else begin
        ctl_r[k] <= ctl_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    lx_r[0] <= x_e;
    ly_r[0] <= y_e;
    for (int k = 1; k < 11; k++) begin
      lx_r[k] <= lx_r[k-1];
      ly_r[k] <= ly_r[k-1];
    end

    f_xx_r <= lx_r[0] * lx_r[0];
    f_yy_r <= ly_r[0] * ly_r[0];
    f_xy_r <= lx_r[0] * ly_r[0];

    g_xx_r <= sg_xx[31:0];
    g_yy_r <= sg_yy[31:0];
    g_xy_r <= sg_xy[31:0];

    h_r2_r <= sh_r2[31:0];
    h_xx_r <= g_xx_r;
    h_yy_r <= g_yy_r;
    h_xy_r <= g_xy_r;

    i_r2r2_r <= h_r2_r * h_r2_r;
    i_k1r2_r <= coef_r[CI_K1] * h_r2_r;
    i_r2_r   <= h_r2_r;
    i_a_r    <= si_a[31:0];
    i_b_r    <= si_b[31:0];
    i_xy_r   <= h_xy_r;

    j_r4_r  <= sj_r4[31:0];
    j_m17_r <= sj_m17[31:0];
    j_r2_r  <= i_r2_r;
    j_a_r   <= i_a_r;
    j_b_r   <= i_b_r;
    j_xy_r  <= i_xy_r;

    k_r6p_r  <= j_r4_r * j_r2_r;
    k_m18p_r <= coef_r[CI_K2] * j_r4_r;
    k_t1p_r  <= coef_r[CI_P1] * j_xy_r;
    k_t2p_r  <= coef_r[CI_P2] * j_a_r;
    k_t3p_r  <= coef_r[CI_P1] * j_b_r;
    k_t4p_r  <= coef_r[CI_P2] * j_xy_r;
    k_m17_r  <= j_m17_r;

    l_r6_r  <= sl_r6[31:0];
    l_m18_r <= sl_m18[31:0];
    l_t1_r  <= sl_t1[31:0];
    l_t2_r  <= sl_t2[31:0];
    l_t3_r  <= sl_t3[31:0];
    l_t4_r  <= sl_t4[31:0];
    l_m17_r <= k_m17_r;

    m_m21p_r <= coef_r[CI_K3] * l_r6_r;
    m_m17_r  <= l_m17_r;
    m_m18_r  <= l_m18_r;
    m_t1_r   <= l_t1_r;
    m_t2_r   <= l_t2_r;
    m_t3_r   <= l_t3_r;
    m_t4_r   <= l_t4_r;

    n_m21_r <= sn_m21[31:0];
    n_m17_r <= m_m17_r;
    n_m18_r <= m_m18_r;
    n_t1_r  <= m_t1_r;
    n_t2_r  <= m_t2_r;
    n_t3_r  <= m_t3_r;
    n_t4_r  <= m_t4_r;

    o_rad_r <= so_rad[31:0];
    o_t1_r  <= n_t1_r;
    o_t2_r  <= n_t2_r;
    o_t3_r  <= n_t3_r;
    o_t4_r  <= n_t4_r;

    p_xr_r <= lx_r[10] * o_rad_r;
    p_yr_r <= ly_r[10] * o_rad_r;
    p_t1_r <= o_t1_r;
    p_t2_r <= o_t2_r;
    p_t3_r <= o_t3_r;
    p_t4_r <= o_t4_r;

    q_mx_r <= sq_mx[31:0];
    q_my_r <= sq_my[31:0];
    q_t1_r <= p_t1_r;
    q_t2_r <= p_t2_r;
    q_t3_r <= p_t3_r;
    q_t4_r <= p_t4_r;

    r_dx_r <= sr_dx[31:0];
    r_dy_r <= sr_dy[31:0];

    s_fx_r <= coef_r[CI_FX] * r_dx_r;
    s_sk_r <= coef_r[CI_SKEW] * r_dy_r;
    s_fy_r <= coef_r[CI_FY] * r_dy_r;
  end

  // result register
  always_ff @(posedge clk) begin
    out_pixel_x   <= ctl_r[NPOST-1].inf ? $signed(st_u[31:0]) : 32'sd0;
    out_pixel_y   <= ctl_r[NPOST-1].inf ? $signed(st_v[31:0]) : 32'sd0;
    out_in_front  <= ctl_r[NPOST-1].inf;
    out_saturated <= ctl_r[NPOST-1].inf &&
                     (ctl_r[NPOST-1].sat || st_u[32] || st_v[32]);
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl_r[NPOST-1].vld;
    end
  end

  always_comb begin
    pipe_busy = a_vld_r | b_vld_r | c_vld_r;
    for (int k = 0; k <= NDIV; k++) begin
      pipe_busy = pipe_busy | dv[k].vld;
    end
    for (int k = 0; k < NPOST; k++) begin
      pipe_busy = pipe_busy | ctl_r[k].vld;
    end
  end

endmodule

/* hw/rtl/cpp_checker.sv */
`timescale 1ns / 1ps
module cpp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input logic signed [31:0] out_pixel_x,
  input logic signed [31:0] out_pixel_y,
  input logic               out_in_front,
  input logic               out_saturated
);

  // a point behind the camera gives a zeroed item
  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_front |-> out_pixel_x == 32'sd0 && out_pixel_y == 32'sd0
                                   && !out_saturated)
    else $error("behind-camera item not zeroed");

  a_rst_no_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_rst_not_busy: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");

endmodule

bind camera_point_projection cpp_checker u_cpp_checker (.*);

/* bench/camera_point_projection_test.sv */
`timescale 1ns / 1ps
module camera_point_projection_test;
  import cpp_pkg::*;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               front;
    logic               sat;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = CMD_LOAD;
  logic [4:0] in_coef_index = '0;
  logic signed [31:0] in_coef_value = '0;
  logic signed [31:0] in_world_x = '0;
  logic signed [31:0] in_world_y = '0;
  logic signed [31:0] in_world_z = '0;
  logic out_valid;
  logic signed [31:0] out_pixel_x;
  logic signed [31:0] out_pixel_y;
  logic out_in_front;
  logic out_saturated;

  logic signed [31:0] coefs [NUM_COEF];
  pixel_t pending_pixels [$];
  bit pred_sat = 1'b0;
  int errors = 0;

  camera_point_projection i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_coef_index(in_coef_index), .in_coef_value(in_coef_value),
    .in_world_x(in_world_x), .in_world_y(in_world_y), .in_world_z(in_world_z),
    .out_valid(out_valid), .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_in_front(out_in_front), .out_saturated(out_saturated)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint flr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clampw(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      pred_sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      pred_sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint mq(longint a, longint b);
    return clampw(flr(a * b, 28), 32);
  endfunction

  function automatic longint divq(longint num, longint den);
    longint unsigned an;
    longint unsigned d;
    longint unsigned q;
    longint unsigned rm;
    an = num < 0 ? -num : num;
    d = den;
    q = an / d;
    rm = an % d;
    if (q >= 8) begin
      pred_sat = 1'b1;
      q = 64'h7FFF_FFFF;
    end else begin
      for (int i = 0; i < 28; i++) begin
        rm = rm << 1;
        q = q << 1;
        if (rm >= d) begin
          rm = rm - d;
          q = q | 1;
        end
      end
    end
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic pixel_t project_point(logic signed [31:0] wx, logic signed [31:0] wy,
                                           logic signed [31:0] wz);
    pixel_t p;
    longint w[3];
    longint c[3];
    longint acc, x, y, xx, yy, xy, r2, r4, r6, rad, dx, dy, u, v;
    pred_sat = 1'b0;
    w[0] = wx;
    w[1] = wy;
    w[2] = wz;
    for (int i = 0; i < 3; i++) begin
      acc = coefs[CI_T0 + i];
      for (int j = 0; j < 3; j++) acc += flr(longint'(coefs[i * 3 + j]) * w[j], 30);
      c[i] = clampw(acc, 32);
    end
    p.px = 0;
    p.py = 0;
    p.front = 0;
    p.sat = 0;
    if (c[2] <= 0) return p;
    x = divq(c[0], c[2]);
    y = divq(c[1], c[2]);
    xx = mq(x, x);
    yy = mq(y, y);
    xy = mq(x, y);
    r2 = clampw(xx + yy, 32);
    r4 = mq(r2, r2);
    r6 = mq(r4, r2);
    rad = clampw(longint'(Q28_ONE) + mq(coefs[CI_K1], r2) + mq(coefs[CI_K2], r4)
                 + mq(coefs[CI_K3], r6), 32);
    dx = clampw(mq(x, rad) + 2 * mq(coefs[CI_P1], xy)
                + mq(coefs[CI_P2], clampw(r2 + 2 * xx, 32)), 32);
    dy = clampw(mq(y, rad) + mq(coefs[CI_P1], clampw(r2 + 2 * yy, 32))
                + 2 * mq(coefs[CI_P2], xy), 32);
    u = clampw(flr(longint'(coefs[CI_FX]) * dx, 28) + flr(longint'(coefs[CI_SKEW]) * dy, 28)
               + coefs[CI_CX], 32);
    v = clampw(flr(longint'(coefs[CI_FY]) * dy, 28) + coefs[CI_CY], 32);
    p.px = u[31:0];
    p.py = v[31:0];
    p.front = 1;
    p.sat = pred_sat;
    return p;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        report("unexpected item", out_pixel_x, 0);
      end else begin
        e = pending_pixels.pop_front();
        if (out_pixel_x !== e.px) report("pixel_x", out_pixel_x, e.px);
        if (out_pixel_y !== e.py) report("pixel_y", out_pixel_y, e.py);
        if (out_in_front !== e.front) report("in_front", out_in_front, e.front);
        if (out_saturated !== e.sat) report("saturated", out_saturated, e.sat);
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(logic cmd, logic [4:0] idx, logic signed [31:0] val,
                           logic signed [31:0] wx, logic signed [31:0] wy,
                           logic signed [31:0] wz);
    start <= 1'b1;
    in_cmd <= cmd;
    in_coef_index <= idx;
    in_coef_value <= val;
    in_world_x <= wx;
    in_world_y <= wy;
    in_world_z <= wz;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd == CMD_LOAD) begin
      if (idx < NUM_COEF) coefs[idx] = val;
    end else begin
      pending_pixels.insert(pending_pixels.size(), project_point(wx, wy, wz));
    end
    idle_gap();
  endtask

  task automatic load(logic [4:0] idx, logic signed [31:0] val);
    send_item(CMD_LOAD, idx, val, $urandom, $urandom, $urandom);
  endtask

  task automatic point(logic signed [31:0] wx, logic signed [31:0] wy, logic signed [31:0] wz);
    send_item(CMD_PROJ, 5'($urandom), $urandom, wx, wy, wz);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic load_camera(bit wild);
    int k;
    for (int i = 0; i < 9; i++)
      load(5'(i), (i % 4 == 0) ? 32'sh4000_0000 : (wild ? $urandom : $urandom_range(0, 1 << 27)
           - (1 << 26)));
    for (int i = 9; i < 12; i++)
      load(5'(i), wild ? $urandom : $urandom_range(0, 1 << 22) - (1 << 21));
    load(CI_T0 + 5'd2, 32'sh000a_0000);
    load(CI_FX, wild ? $urandom : 32'sh0200_0000 + $urandom_range(0, 1 << 24));
    load(CI_SKEW, wild ? $urandom : $urandom_range(0, 1 << 16));
    load(CI_CX, wild ? $urandom : 32'sh0140_0000);
    load(CI_FY, wild ? $urandom : 32'sh0200_0000 + $urandom_range(0, 1 << 24));
    load(CI_CY, wild ? $urandom : 32'sh00f0_0000);
    for (k = CI_K1; k <= CI_K3; k++)
      load(5'(k), wild ? $urandom : $urandom_range(0, 1 << 25) - (1 << 24));
  endtask

  task automatic test_unloaded();
    point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    drain();
  endtask

  task automatic test_directed();
    load_camera(0);
    point(0, 0, 0);
    point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    point(32'sh0001_0000, 32'shffff_0000, 32'sh8000_0000);
    point(32'sh7fff_ffff, 0, 32'shfff6_0001);
    load(5'd22, 32'sh7fff_ffff);
    load(5'd31, 32'sh8000_0000);
    point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    load(CI_K1, 32'sh7fff_ffff);
    load(CI_FX, 32'sh8000_0000);
    point(32'sh0050_0000, 32'sh0050_0000, 32'sh0001_0000);
    drain();
  endtask

  task automatic test_random(int count, bit wild);
    int kind;
    load_camera(wild);
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        drain();
        load(5'($urandom_range(0, 31)), $urandom);
      end else if (kind < 4) begin
        point($urandom, $urandom, $urandom);
      end else begin
        point($urandom_range(0, 1 << 22) - (1 << 21), $urandom_range(0, 1 << 22) - (1 << 21),
              $urandom_range(0, 1 << 23) - (1 << 21));
      end
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < NUM_COEF; i++) coefs[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unloaded();
    test_directed();
    test_random(250, 0);
    test_random(200, 1);
    test_random(200, 0);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
